### design/ktsr_pkg.sv
// ----------------------------------------------------------------------------
// ktsr_pkg
// Shared types and codes for the sorted key/payload table: operation and
// status codes, the command broadcast to the cell row, and one table entry.
// ----------------------------------------------------------------------------
package ktsr_pkg;

	localparam int KEY_W = 16;
	localparam int PAY_W = 32;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_UPDATE = 2'd1,
		OP_DELETE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// Status codes of a result.
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DUP     = 3'd1,
		ST_FULL    = 3'd2,
		ST_MISSING = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	// What the cell row does in this cycle.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_INSERT,
		CMD_UPDATE,
		CMD_DELETE,
		CMD_ROTATE
	} cmd_kind_t;

	// One table entry.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	// Command broadcast to every cell.
	typedef struct packed {
		cmd_kind_t        kind;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} cmd_t;

endpackage

### design/ktsr_req_if.sv
// ----------------------------------------------------------------------------
// ktsr_req_if
// Request channel of the sorted table: valid/ready handshake with the
// operation, key and payload of one request.
// ----------------------------------------------------------------------------
interface ktsr_req_if;

	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] key;
	logic [31:0] payload;

	modport source (output valid, output op, output key, output payload, input ready);
	modport sink (input valid, input op, input key, input payload, output ready);

endinterface

### design/ktsr_rsp_if.sv
// ----------------------------------------------------------------------------
// ktsr_rsp_if
// Result channel of the sorted table: valid/ready handshake with status,
// entry key, entry payload and the last-result mark.
// ----------------------------------------------------------------------------
interface ktsr_rsp_if;

	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] entry_key;
	logic [31:0] entry_payload;
	logic        last;

	modport source (output valid, output status, output entry_key, output entry_payload,
		output last, input ready);
	modport sink (input valid, input status, input entry_key, input entry_payload,
		input last, output ready);

endinterface

### design/ktsr_cell.sv
// ----------------------------------------------------------------------------
// ktsr_cell
// One slot of the sorted table. It compares its key against the broadcast
// key and, from its own and its neighbors' compare flags, keeps its entry,
// loads the new one, or takes the entry of a neighbor.
// ----------------------------------------------------------------------------
module ktsr_cell
	import ktsr_pkg::*;
(
	input  logic   clk,
	input  cmd_t   cmd,
	input  logic   valid,
	input  logic   tail,
	input  logic   prev_lt,
	input  logic   prev_valid,
	input  entry_t prev_entry,
	input  entry_t next_entry,
	input  entry_t head_entry,
	output entry_t entry,
	output logic   lt,
	output logic   eq
);

	entry_t entry_q;

	// Compare flags; a slot beyond the fill level never matches.
	always_comb begin
		lt = valid && (entry_q.key < cmd.key);
		eq = valid && (entry_q.key == cmd.key);
	end

	// Slot update. Keys ascend along the row, so the first slot that is not
	// below the request key is where an insert lands or a delete starts.
	always_ff @(posedge clk) begin
		case (cmd.kind)
			CMD_INSERT: begin
				if (!lt) begin
					if (prev_lt) begin
						entry_q <= '{key: cmd.key, payload: cmd.payload};
					end else if (prev_valid) begin
						entry_q <= prev_entry;
					end
				end
			end
			CMD_UPDATE: begin
				if (eq) begin
					entry_q.payload <= cmd.payload;
				end
			end
			CMD_DELETE: begin
				if (valid && !lt) begin
					entry_q <= next_entry;
				end
			end
			CMD_ROTATE: begin
				if (tail) begin
					entry_q <= head_entry;
				end else if (valid) begin
					entry_q <= next_entry;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;

endmodule

### design/ktsr_chain.sv
// ----------------------------------------------------------------------------
// ktsr_chain
// Row of table cells. Wires each cell to its neighbors, derives the fill
// flags from the entry count and reduces the match flags of the row.
// ----------------------------------------------------------------------------
module ktsr_chain
	import ktsr_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int CNT_W = 7
)(
	input  logic             clk,
	input  cmd_t             cmd,
	input  logic [CNT_W-1:0] count,
	output logic             hit,
	output entry_t           head
);

	entry_t             entries [DEPTH];
	logic   [DEPTH-1:0] lt_vec;
	logic   [DEPTH-1:0] eq_vec;
	logic   [DEPTH-1:0] valid_vec;

	// Cell row with neighbor links; the first cell sees a virtual smaller key.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
		localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);

		logic   tail;
		logic   prev_lt;
		logic   prev_valid;
		entry_t prev_entry;
		entry_t next_entry;

		assign valid_vec[i] = IDX < count;
		assign tail         = IDX1 == count;

		if (i == 0) begin : g_first
			assign prev_lt    = 1'b1;
			assign prev_valid = 1'b0;
			assign prev_entry = '0;
		end else begin : g_mid
			assign prev_lt    = lt_vec[i-1];
			assign prev_valid = valid_vec[i-1];
			assign prev_entry = entries[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign next_entry = entries[i];
		end else begin : g_inner
			assign next_entry = entries[i+1];
		end

		ktsr_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (valid_vec[i]),
			.tail       (tail),
			.prev_lt    (prev_lt),
			.prev_valid (prev_valid),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.head_entry (entries[0]),
			.entry      (entries[i]),
			.lt         (lt_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	// Any valid slot holding the request key.
	assign hit  = |eq_vec;
	assign head = entries[0];

endmodule

### design/keyed_table_sorted_readout.sv
// Timing: an insert, update or delete result, and the single result of a read on an
// empty table, is visible in the cycle after its request is accepted; a read of a
// filled table enters the read state, then streams one entry per cycle from the row
// head. Throughput: one insert, update or delete per cycle. Both hold while results
// are taken; a read holds off requests until the row has rotated through every entry.
// Reset: arst_n clears the count, sequencer and result register, not the cells.
// ----------------------------------------------------------------------------
// keyed_table_sorted_readout
// Bounded table of unique 16-bit keys with 32-bit payloads, kept sorted in
// a row of cells, with insert, update, delete and sorted readout.
// ----------------------------------------------------------------------------
module keyed_table_sorted_readout
	import ktsr_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
)(
	input  logic       clk,
	input  logic       arst_n,
	ktsr_req_if.sink   req,
	ktsr_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] remain_q;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [KEY_W-1:0] out_key_q;
	logic [PAY_W-1:0] out_payload_q;
	logic             out_last_q;

	cmd_t             cmd;
	logic             hit;
	entry_t           head;
	logic             out_free;
	logic             out_load;
	logic             accept;
	status_t          res_status;
	logic             start_read;

	// Request side is open only between reads and while the result slot frees.
	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	// The result register takes a new result on a non-streaming request or a read step.
	assign out_load  = (state_q == S_IDLE) ? (accept && !start_read) : out_free;

	// Decode of an accepted request against the current table, or of a read step.
	always_comb begin
		cmd        = '{kind: CMD_NONE, key: req.key, payload: req.payload};
		res_status = ST_OK;
		start_read = 1'b0;
		if (state_q == S_READ) begin
			if (out_free) begin
				cmd.kind = CMD_ROTATE;
			end
		end else if (accept) begin
			case (op_t'(req.op))
				OP_INSERT: begin
					if (count_q == FULL_CNT) begin
						res_status = ST_FULL;
					end else if (hit) begin
						res_status = ST_DUP;
					end else begin
						cmd.kind = CMD_INSERT;
					end
				end
				OP_UPDATE, OP_DELETE: begin
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else if (!hit) begin
						res_status = ST_MISSING;
					end else begin
						cmd.kind = (op_t'(req.op) == OP_UPDATE) ? CMD_UPDATE : CMD_DELETE;
					end
				end
				OP_READ: begin
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else begin
						start_read = 1'b1;
					end
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	ktsr_chain #(
		.DEPTH (TABLE_DEPTH),
		.CNT_W (CNT_W)
	) u_chain (
		.clk   (clk),
		.cmd   (cmd),
		.count (count_q),
		.hit   (hit),
		.head  (head)
	);

	// Sequencer, entry count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			remain_q      <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_OK;
			out_key_q     <= '0;
			out_payload_q <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (start_read) begin
							state_q  <= S_READ;
							remain_q <= count_q;
						end else begin
							out_status_q  <= res_status;
							out_key_q     <= (op_t'(req.op) == OP_READ) ? '0 : req.key;
							out_payload_q <= '0;
							out_last_q    <= 1'b1;
						end
						if (cmd.kind == CMD_INSERT) begin
							count_q <= count_q + ONE_CNT;
						end else if (cmd.kind == CMD_DELETE) begin
							count_q <= count_q - ONE_CNT;
						end
					end
				end
				S_READ: begin
					if (out_free) begin
						out_status_q  <= ST_OK;
						out_key_q     <= head.key;
						out_payload_q <= head.payload;
						out_last_q    <= (remain_q == ONE_CNT);
						remain_q      <= remain_q - ONE_CNT;
						if (remain_q == ONE_CNT) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.entry_key     = out_key_q;
	assign rsp.entry_payload = out_payload_q;
	assign rsp.last          = out_last_q;

	// The fill level never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count beyond table depth");

	// A read in progress always has entries left to stream.
	a_read_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (remain_q != '0) && (remain_q <= count_q))
		else $error("read sequencer out of range");

	// A successful insert grows the table by exactly one entry.
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.kind == CMD_INSERT) |=> (count_q == $past(count_q) + ONE_CNT))
		else $error("insert did not grow the table");

	// Each streamed entry takes one rotation of the row.
	a_rotate_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.kind == CMD_ROTATE) |=> out_valid_q && (out_status_q == ST_OK))
		else $error("rotation without an emitted entry");

endmodule

### verif/keyed_table_sorted_readout_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_table_sorted_readout_tb
// Self-checking bench for the sorted key/payload table. A short table of
// directed requests covers the empty, duplicate and missing-key cases and
// the key and payload extremes. Random traffic then fills the table, hits it
// when full, churns and drains it. Every result is compared in order against a
// hand-typed result or a behavioral copy of the table; both channels idle at random at first.
// ----------------------------------------------------------------------------
module keyed_table_sorted_readout_tb;

	import ktsr_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int RAND_ITEMS   = 250;
	localparam int PHASE_B_AT   = 100;
	localparam int PHASE_C_AT   = 200;
	localparam int DRAIN_AT     = 150;
	localparam int STALL_CYCLES = 300;
	localparam int END_CYCLES   = 16;

	// One result as the block reports it.
	typedef struct packed {
		status_t          status;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic             last;
	} result_t;

	// One row of the directed table; res holds the hand-typed result where known.
	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic             typed;
		result_t          res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	ktsr_req_if req ();
	ktsr_rsp_if rsp ();

	keyed_table_sorted_readout #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Behavioral copy of the table, kept sorted by key.
	logic [KEY_W-1:0] tbl_key [TABLE_DEPTH];
	logic [PAY_W-1:0] tbl_pay [TABLE_DEPTH];
	int               tbl_count;

	result_t outcome_buf [TABLE_DEPTH];
	result_t pending_results [$];
	row_t    directed_rows [$];

	int errors      = 0;
	int sent_count  = 0;
	int tx_idle_pct = 32;
	int rx_idle_pct = 47;
	bit stall_armed = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t make_result(status_t st, logic [KEY_W-1:0] key,
		logic [PAY_W-1:0] pay, logic last);
		result_t r;
		r.status  = st;
		r.key     = key;
		r.payload = pay;
		r.last    = last;
		return r;
	endfunction

	// Applies one request to the table copy and fills outcome_buf with the
	// results it causes; returns how many there are.
	function automatic int lookup_outcome(op_t op, logic [KEY_W-1:0] key,
		logic [PAY_W-1:0] pay);
		int pos;
		int i;
		bit found;
		found = 1'b0;
		pos = 0;
		for (i = 0; i < tbl_count; i++) begin
			if (!found && tbl_key[i] == key) begin
				found = 1'b1;
				pos = i;
			end
		end
		case (op)
			OP_READ: begin
				if (tbl_count == 0) begin
					outcome_buf[0] = make_result(ST_EMPTY, '0, '0, 1'b1);
					return 1;
				end
				for (i = 0; i < tbl_count; i++)
					outcome_buf[i] = make_result(ST_OK, tbl_key[i], tbl_pay[i],
						i == tbl_count - 1);
				return tbl_count;
			end
			OP_INSERT: begin
				// Fullness wins over a duplicate key.
				if (tbl_count >= TABLE_DEPTH) begin
					outcome_buf[0] = make_result(ST_FULL, key, '0, 1'b1);
					return 1;
				end
				if (found) begin
					outcome_buf[0] = make_result(ST_DUP, key, '0, 1'b1);
					return 1;
				end
				pos = 0;
				while (pos < tbl_count && tbl_key[pos] < key)
					pos++;
				for (i = tbl_count; i > pos; i--) begin
					tbl_key[i] = tbl_key[i-1];
					tbl_pay[i] = tbl_pay[i-1];
				end
				tbl_key[pos] = key;
				tbl_pay[pos] = pay;
				tbl_count++;
			end
			default: begin
				if (tbl_count == 0) begin
					outcome_buf[0] = make_result(ST_EMPTY, key, '0, 1'b1);
					return 1;
				end
				if (!found) begin
					outcome_buf[0] = make_result(ST_MISSING, key, '0, 1'b1);
					return 1;
				end
				if (op == OP_UPDATE) begin
					tbl_pay[pos] = pay;
				end else begin
					for (i = pos; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i+1];
						tbl_pay[i] = tbl_pay[i+1];
					end
					tbl_count--;
				end
			end
		endcase
		outcome_buf[0] = make_result(ST_OK, key, '0, 1'b1);
		return 1;
	endfunction

	// A key already in the table when asked and possible, otherwise a random one.
	function automatic logic [KEY_W-1:0] pick_key(bit present);
		if (present && tbl_count > 0)
			return tbl_key[$urandom_range(tbl_count - 1)];
		return KEY_W'($urandom);
	endfunction

	task automatic add_row(op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay,
		bit typed, status_t st, logic [KEY_W-1:0] exp_key);
		row_t row;
		row.op      = op;
		row.key     = key;
		row.payload = pay;
		row.typed   = typed;
		row.res     = make_result(st, exp_key, '0, 1'b1);
		directed_rows.push_back(row);
	endtask

	// Offers one request, waits for it to be taken and records what it should
	// cause. valid stays high into the next request unless a gap is rolled.
	task automatic send_request(op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay,
		bit typed, result_t typed_res);
		int n;
		int i;
		if (sent_count == PHASE_B_AT) begin
			tx_idle_pct = 47;
			rx_idle_pct = 32;
		end
		if (sent_count == PHASE_C_AT) begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
			stall_armed = 1'b1;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.op      <= op;
		req.key     <= key;
		req.payload <= pay;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		n = lookup_outcome(op, key, pay);
		if (typed)
			pending_results.push_back(typed_res);
		else
			for (i = 0; i < n; i++)
				pending_results.push_back(outcome_buf[i]);
		sent_count++;
	endtask

	// Request stimulus and end of run.
	initial begin : stimulus
		int r;
		int directed_n;
		bit drained;
		result_t none;
		none = make_result(ST_OK, '0, '0, 1'b0);
		drained = 1'b0;
		tbl_count = 0;
		arst_n      <= 1'b0;
		req.valid   <= 1'b0;
		req.op      <= OP_INSERT;
		req.key     <= '0;
		req.payload <= '0;

		add_row(OP_READ,   16'hFFFF, 32'hFFFF_FFFF, 1, ST_EMPTY,   16'h0000);
		add_row(OP_UPDATE, 16'h1234, 32'h0000_0001, 1, ST_EMPTY,   16'h1234);
		add_row(OP_DELETE, 16'hFFFF, 32'h0000_0000, 1, ST_EMPTY,   16'hFFFF);
		add_row(OP_INSERT, 16'h8000, 32'hDEAD_BEEF, 1, ST_OK,      16'h8000);
		add_row(OP_INSERT, 16'h0000, 32'hFFFF_FFFF, 1, ST_OK,      16'h0000);
		add_row(OP_INSERT, 16'hFFFF, 32'h0000_0000, 1, ST_OK,      16'hFFFF);
		add_row(OP_INSERT, 16'h8000, 32'h0000_0001, 1, ST_DUP,     16'h8000);
		add_row(OP_READ,   16'h0000, 32'h0000_0000, 0, ST_OK,      16'h0000);
		add_row(OP_UPDATE, 16'hFFFF, 32'hFFFF_FFFF, 1, ST_OK,      16'hFFFF);
		add_row(OP_UPDATE, 16'h1111, 32'h1234_5678, 1, ST_MISSING, 16'h1111);
		add_row(OP_DELETE, 16'h2222, 32'h0000_0000, 1, ST_MISSING, 16'h2222);
		add_row(OP_INSERT, 16'h7FFF, 32'h5555_5555, 1, ST_OK,      16'h7FFF);
		add_row(OP_INSERT, 16'h0001, 32'hAAAA_AAAA, 1, ST_OK,      16'h0001);
		add_row(OP_READ,   16'h5A5A, 32'hA5A5_A5A5, 0, ST_OK,      16'h0000);
		add_row(OP_DELETE, 16'h0000, 32'h0000_0000, 0, ST_OK,      16'h0000);
		add_row(OP_DELETE, 16'hFFFF, 32'hFFFF_FFFF, 0, ST_OK,      16'h0000);
		add_row(OP_DELETE, 16'h7FFF, 32'h0000_0000, 0, ST_OK,      16'h0000);
		add_row(OP_READ,   16'h0000, 32'h0000_0000, 0, ST_OK,      16'h0000);
		add_row(OP_UPDATE, 16'h8000, 32'h0000_0000, 0, ST_OK,      16'h0000);
		add_row(OP_READ,   16'h0000, 32'h0000_0000, 0, ST_OK,      16'h0000);
		add_row(OP_DELETE, 16'h8000, 32'h0000_0000, 0, ST_OK,      16'h0000);
		add_row(OP_DELETE, 16'h0001, 32'h0000_0000, 0, ST_OK,      16'h0000);
		add_row(OP_READ,   16'hABCD, 32'h1234_5678, 1, ST_EMPTY,   16'h0000);
		directed_n = directed_rows.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].key,
				directed_rows[i].payload, directed_rows[i].typed, directed_rows[i].res);

		// Fill to capacity, then hit the full table with new and present keys.
		while (tbl_count < TABLE_DEPTH)
			send_request(OP_INSERT, pick_key(0), $urandom, 0, none);
		send_request(OP_INSERT, pick_key(1), $urandom, 0, none);
		send_request(OP_INSERT, pick_key(0), $urandom, 0, none);
		send_request(OP_UPDATE, pick_key(1), $urandom, 0, none);
		send_request(OP_READ, KEY_W'($urandom), $urandom, 0, none);

		// Mixed traffic with one full drain along the way.
		while (sent_count < directed_n + RAND_ITEMS) begin
			if (!drained && sent_count >= directed_n + DRAIN_AT) begin
				drained = 1'b1;
				while (tbl_count > 0)
					send_request(OP_DELETE, pick_key(1), $urandom, 0, none);
				send_request(OP_UPDATE, pick_key(0), $urandom, 0, none);
				send_request(OP_DELETE, pick_key(0), $urandom, 0, none);
				send_request(OP_READ, KEY_W'($urandom), $urandom, 0, none);
			end
			r = $urandom_range(99);
			if (r < 10)
				send_request(OP_READ, KEY_W'($urandom), $urandom, 0, none);
			else if (r < 40)
				send_request(OP_INSERT, pick_key($urandom_range(3) == 0), $urandom, 0, none);
			else if (r < 65)
				send_request(OP_UPDATE, pick_key($urandom_range(4) != 0), $urandom, 0, none);
			else if (r < 90)
				send_request(OP_DELETE, pick_key($urandom_range(4) != 0), $urandom, 0, none);
			else
				send_request(op_t'($urandom_range(3)), KEY_W'($urandom), $urandom, 0, none);
		end
		req.valid <= 1'b0;

		// Let the last results drain out, then a few quiet cycles.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result sink: random back-pressure, one long hold-off, in-order compare.
	initial begin : result_sink
		result_t want;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result status %0d key %h payload %h last %b",
						$time, rsp.status, rsp.entry_key, rsp.entry_payload, rsp.last);
				end else begin
					want = pending_results.pop_front();
					if ({rsp.status, rsp.entry_key, rsp.entry_payload, rsp.last} !==
						{want.status, want.key, want.payload, want.last}) begin
						errors++;
						$display("%0t: mismatch expected status %0d key %h payload %h last %b",
							$time, want.status, want.key, want.payload, want.last);
						$display("%0t:          actual   status %0d key %h payload %h last %b",
							$time, rsp.status, rsp.entry_key, rsp.entry_payload, rsp.last);
					end
				end
			end
			// Hold off once so the block backs up and stalls its request side.
			if (stall_armed) begin
				stall_armed = 1'b0;
				rsp.ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end
			rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Run limit.
	initial begin : watchdog
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
design/ktsr_pkg.sv
design/ktsr_req_if.sv
design/ktsr_rsp_if.sv
design/ktsr_cell.sv
design/ktsr_chain.sv
design/keyed_table_sorted_readout.sv
verif/keyed_table_sorted_readout_tb.sv
